/* sv/rccc_pkg.sv */
`timescale 1ns / 1ps

package rccc_pkg;

  localparam int DBZ_W       = 8;
  localparam int LEVEL_W     = 7;
  localparam int THR_W       = 38;
  localparam int SUM_W       = 44;
  localparam int PROD_W      = THR_W + LEVEL_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = THR_W;
  localparam int Z_W         = 38;
  localparam int Z_ENTRIES   = 165;
  localparam int Z_IDX_W     = 8;

  // lowest sample that counts as signal is one step above the floor
  localparam logic signed [DBZ_W-1:0] SIGNAL_FLOOR   = -8'sd38;
  localparam logic signed [DBZ_W:0]   GRADIENT_STEPS = 9'sd10;
  localparam logic signed [DBZ_W:0]   Z_OFFSET       = 9'sd37;

  localparam logic [LEVEL_W-1:0] MIN_SIGNAL_RESET = 7'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BAND_BOTTOM = 3'd0,
    REG_BAND_TOP    = 3'd1,
    REG_ABOVE_LIMIT = 3'd2,
    REG_MIN_SIGNAL  = 3'd3,
    REG_MEAN_THRESH = 3'd4
  } cfg_reg_t;

  typedef logic [Z_W-1:0] z_table_t [Z_ENTRIES];

  // 10^(r/20) scaled by 1e9
  localparam logic [63:0] ROOT_TAB [20] = '{
    64'd1000000000, 64'd1122018454, 64'd1258925412, 64'd1412537545,
    64'd1584893192, 64'd1778279410, 64'd1995262315, 64'd2238721139,
    64'd2511886432, 64'd2818382931, 64'd3162277660, 64'd3548133892,
    64'd3981071706, 64'd4466835922, 64'd5011872336, 64'd5623413252,
    64'd6309573445, 64'd7079457844, 64'd7943282347, 64'd8912509381
  };

  localparam logic [127:0] BILLION        = 128'd1000000000;
  localparam logic [127:0] HALF_BILLION   = 128'd500000000;
  localparam logic [127:0] TEN_BILLION    = 128'd10000000000;
  localparam logic [127:0] HALF_TEN_BIL   = 128'd5000000000;
  localparam logic [127:0] HUNDRED_BIL    = 128'd100000000000;
  localparam logic [127:0] HALF_HUNDR_BIL = 128'd50000000000;

  // entry i holds linear Z for sample i - 37, 16 fraction bits, rounded half up
  function automatic z_table_t build_z_table();
    z_table_t     tab;
    logic [127:0] n;
    int           shifted;
    int           q;
    int           r;
    for (int i = 0; i < Z_ENTRIES; i++) begin
      shifted = i + 3;
      q = shifted / 20 - 2;
      r = shifted % 20;
      n = 128'(ROOT_TAB[r]) * 128'd65536;
      if (q >= 0) begin
        for (int j = 0; j < q; j++) begin
          n = n * 128'd10;
        end
        n = (n + HALF_BILLION) / BILLION;
      end else if (q == -1) begin
        n = (n + HALF_TEN_BIL) / TEN_BILLION;
      end else begin
        n = (n + HALF_HUNDR_BIL) / HUNDRED_BIL;
      end
      tab[i] = n[Z_W-1:0];
    end
    return tab;
  endfunction

  localparam z_table_t Z_TABLE = build_z_table();

endpackage

/* sv/radar_column_convective_classifier.sv */
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------
// in       | in_valid/in_ready   | dbz_sample, column_end
// out      | out_valid/out_ready | convective_flag, stratiform_flag
// cfg      | cfg_write           | cfg_index, cfg_data
//
// one sample per cycle while no top sample waits on a stalled result:
// input register, then table lookup, accumulate and compare into the state
// and result registers. rst clears the state and loads register defaults.
// a stalled result blocks only the next top sample; other samples keep
// flowing past it.
module radar_column_convective_classifier #(
  parameter int MAX_LEVELS   = 64,
  parameter int LEVEL_OFFSET = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rccc_pkg::DBZ_W-1:0]     dbz_sample,
  input  logic                                  column_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  convective_flag,
  output logic                                  stratiform_flag,
  input  logic                                  cfg_write,
  input  logic [rccc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rccc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import rccc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);

  logic [LEVEL_W-1:0] band_bottom;
  logic [LEVEL_W-1:0] band_top;
  logic [LEVEL_W-1:0] above_limit;
  logic [LEVEL_W-1:0] min_signal;
  logic [THR_W-1:0]   mean_thresh;

  logic                    req_valid;
  logic signed [DBZ_W-1:0] req_sample;
  logic                    req_end;

  logic [CNT_W-1:0]        level_counter;
  logic signed [DBZ_W-1:0] recent [LEVEL_OFFSET];
  logic [SUM_W-1:0]        z_sum;
  logic [LEVEL_W-1:0]      signal_count;
  logic                    strat_seen;

  logic [CNT_W-1:0]        level_counter_next;
  logic [SUM_W-1:0]        z_sum_next;
  logic [LEVEL_W-1:0]      signal_count_next;
  logic                    strat_seen_next;

  logic                    out_free;
  logic                    proc_fire;
  logic                    in_column;
  logic [LEVEL_W-1:0]      level;
  logic [LEVEL_W-1:0]      lower_level;
  logic                    in_span;
  logic                    has_signal;
  logic signed [DBZ_W:0]   z_idx_wide;
  logic [Z_W-1:0]          z_value;
  logic signed [DBZ_W:0]   drop;
  logic [PROD_W-1:0]       thresh_total;
  logic                    conv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      band_bottom <= '0;
      band_top    <= '0;
      above_limit <= '0;
      min_signal  <= MIN_SIGNAL_RESET;
      mean_thresh <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BAND_BOTTOM: band_bottom <= cfg_data[LEVEL_W-1:0];
        REG_BAND_TOP:    band_top    <= cfg_data[LEVEL_W-1:0];
        REG_ABOVE_LIMIT: above_limit <= cfg_data[LEVEL_W-1:0];
        REG_MIN_SIGNAL:  min_signal  <= cfg_data[LEVEL_W-1:0];
        REG_MEAN_THRESH: mean_thresh <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign proc_fire = req_valid && (!req_end || out_free);
  assign in_ready  = !req_valid || proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_sample <= dbz_sample;
      req_end    <= column_end;
    end
  end

  always_comb begin
    in_column   = level_counter < CNT_W'(MAX_LEVELS);
    level       = LEVEL_W'(level_counter);
    lower_level = level - LEVEL_W'(LEVEL_OFFSET);
    in_span     = (level < band_bottom) ||
                  ((level >= band_top) && (level < above_limit));
    has_signal  = req_sample > SIGNAL_FLOOR;
    z_idx_wide  = DBZ_W'(0) + 9'(req_sample) + Z_OFFSET;
    z_value     = has_signal ? Z_TABLE[z_idx_wide[Z_IDX_W-1:0]] : '0;
    drop        = 9'(recent[0]) - 9'(req_sample);

    level_counter_next = level_counter;
    z_sum_next         = z_sum;
    signal_count_next  = signal_count;
    strat_seen_next    = strat_seen;

    if (in_column) begin
      if (in_span && has_signal) begin
        z_sum_next        = z_sum + SUM_W'(z_value);
        signal_count_next = signal_count + 7'd1;
      end
      // compare with the sample LEVEL_OFFSET levels below this one
      if ((level >= LEVEL_W'(LEVEL_OFFSET)) && (lower_level >= band_bottom) &&
          (lower_level < band_top) && (drop > GRADIENT_STEPS)) begin
        strat_seen_next = 1'b1;
      end
      level_counter_next = level_counter + CNT_W'(1);
    end

    thresh_total = PROD_W'(mean_thresh) * PROD_W'(signal_count_next);
    conv = (signal_count_next > min_signal) &&
           (PROD_W'(z_sum_next) > thresh_total);
  end

  // column state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_counter <= '0;
      z_sum         <= '0;
      signal_count  <= '0;
      strat_seen    <= 1'b0;
      for (int i = 0; i < LEVEL_OFFSET; i++) begin
        recent[i] <= '0;
      end
    end else if (proc_fire) begin
      if (req_end) begin
        level_counter <= '0;
        z_sum         <= '0;
        signal_count  <= '0;
        strat_seen    <= 1'b0;
        for (int i = 0; i < LEVEL_OFFSET; i++) begin
          recent[i] <= '0;
        end
      end else begin
        level_counter <= level_counter_next;
        z_sum         <= z_sum_next;
        signal_count  <= signal_count_next;
        strat_seen    <= strat_seen_next;
        if (in_column) begin
          for (int i = 0; i < LEVEL_OFFSET - 1; i++) begin
            recent[i] <= recent[i+1];
          end
          recent[LEVEL_OFFSET-1] <= req_sample;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && req_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && req_end) begin
      convective_flag <= conv;
      stratiform_flag <= strat_seen_next;
    end
  end

endmodule

/* bench/radar_column_convective_classifier_test.sv */
`timescale 1ns / 1ps

module radar_column_convective_classifier_test;
  import rccc_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int SETTLE_GAP   = 4;

  typedef struct packed {
    logic convective;
    logic stratiform;
  } flag_pair_t;

  typedef enum int {
    PROFILE_NOISE,
    PROFILE_WALK,
    PROFILE_FLOOR,
    PROFILE_FLAT
  } profile_t;

  // column predictor: integrates linear Z and tracks the bright-band gradient
  class column_flags_model;
    localparam int TOP_LEVELS = 64;
    localparam int BAND_GAP   = 4;
    localparam int FLOOR_STEP = -38;
    localparam int DROP_STEPS = 10;

    logic [6:0]        band_bottom = '0;
    logic [6:0]        band_top    = '0;
    logic [6:0]        above_limit = '0;
    logic [6:0]        min_levels  = 7'd4;
    logic [37:0]       z_threshold = '0;
    logic [6:0]        level       = '0;
    logic signed [7:0] history [BAND_GAP] = '{default: '0};
    logic [43:0]       z_total     = '0;
    logic [6:0]        hits        = '0;
    bit                strat_seen  = 1'b0;
    flag_pair_t        expected [$];
    int unsigned       errors      = 0;

    // 10^(r/20) times 1e9
    function longint unsigned root_scaled(int r);
      case (r)
        0:  return 64'd1000000000;
        1:  return 64'd1122018454;
        2:  return 64'd1258925412;
        3:  return 64'd1412537545;
        4:  return 64'd1584893192;
        5:  return 64'd1778279410;
        6:  return 64'd1995262315;
        7:  return 64'd2238721139;
        8:  return 64'd2511886432;
        9:  return 64'd2818382931;
        10: return 64'd3162277660;
        11: return 64'd3548133892;
        12: return 64'd3981071706;
        13: return 64'd4466835922;
        14: return 64'd5011872336;
        15: return 64'd5623413252;
        16: return 64'd6309573445;
        17: return 64'd7079457844;
        18: return 64'd7943282347;
        default: return 64'd8912509381;
      endcase
    endfunction

    // s in half-dB steps, result with 16 fraction bits, rounded half up
    function longint unsigned linear_z(int s);
      longint unsigned num;
      longint unsigned div;
      int              shifted;
      int              q;
      shifted = s + 40;
      q = shifted / 20 - 2;
      num = root_scaled(shifted % 20) * 64'd65536;
      div = 64'd1000000000;
      for (int i = 0; i < q; i++) div = div / 64'd10;
      for (int i = 0; i < -q; i++) div = div * 64'd10;
      return (num + div / 64'd2) / div;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [37:0] val);
      case (idx)
        REG_BAND_BOTTOM: band_bottom = val[6:0];
        REG_BAND_TOP:    band_top    = val[6:0];
        REG_ABOVE_LIMIT: above_limit = val[6:0];
        REG_MIN_SIGNAL:  min_levels  = val[6:0];
        REG_MEAN_THRESH: z_threshold = val;
        default: ;
      endcase
    endfunction

    function void clear_column();
      level = '0;
      for (int i = 0; i < BAND_GAP; i++) history[i] = '0;
      z_total = '0;
      hits = '0;
      strat_seen = 1'b0;
    endfunction

    function void note_sample(logic signed [7:0] s, logic last);
      int              m;
      int              sv;
      int              older;
      bit              low_side;
      bit              high_side;
      bit              conv;
      longint unsigned bound;
      flag_pair_t      e;
      m = level;
      sv = s;
      // levels past the column limit are dropped entirely
      if (m < TOP_LEVELS) begin
        low_side = m < int'(band_bottom);
        high_side = m >= int'(band_top) && m < int'(above_limit);
        if ((low_side || high_side) && sv > FLOOR_STEP) begin
          z_total = z_total + 44'(linear_z(sv));
          hits = hits + 7'd1;
        end
        if (m >= BAND_GAP) begin
          older = history[0];
          if (m - BAND_GAP >= int'(band_bottom) && m - BAND_GAP < int'(band_top) &&
              older - sv > DROP_STEPS) begin
            strat_seen = 1'b1;
          end
        end
        for (int i = 0; i < BAND_GAP - 1; i++) history[i] = history[i + 1];
        history[BAND_GAP - 1] = s;
        level = 7'(m + 1);
      end
      if (last) begin
        // mean test without division
        bound = 64'(z_threshold) * 64'(hits);
        conv = hits > min_levels && 64'(z_total) > bound;
        e.convective = conv;
        e.stratiform = strat_seen;
        expected.push_back(e);
        clear_column();
      end
    endfunction

    function void check_flags(logic conv, logic strat);
      flag_pair_t e;
      if (expected.size() == 0) begin
        $error("column result with none pending: convective_flag %0b stratiform_flag %0b",
               conv, strat);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (conv !== e.convective) begin
        $error("convective_flag: expected %0b, actual %0b", e.convective, conv);
        errors++;
      end
      if (strat !== e.stratiform) begin
        $error("stratiform_flag: expected %0b, actual %0b", e.stratiform, strat);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DBZ_W-1:0]  dbz_sample;
  logic                     column_end;
  logic                     out_valid;
  logic                     out_ready;
  logic                     convective_flag;
  logic                     stratiform_flag;
  logic                     cfg_write;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  column_flags_model flags_model = new();
  int                idle_cycles = 0;
  int                stall_left  = 0;
  int                sent_items  = 0;
  bit                steady      = 1'b0;

  radar_column_convective_classifier i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .dbz_sample      (dbz_sample),
    .column_end      (column_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .convective_flag (convective_flag),
    .stratiform_flag (stratiform_flag),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [6:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd64;
    return 7'($urandom_range(0, 64));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(logic signed [7:0] s, logic last);
    int gap;
    in_valid = 1'b1;
    dbz_sample = s;
    column_end = last;
    do @(posedge clk); while (!in_ready);
    flags_model.note_sample(s, last);
    sent_items++;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_series(int vals[$]);
    for (int i = 0; i < vals.size(); i++) begin
      send_sample(vals[i][7:0], i == vals.size() - 1);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [37:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    flags_model.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // wait for every pending column result, then let the pipeline empty
  task automatic drain();
    in_valid = 1'b0;
    while (flags_model.pending() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      flags_model.check_flags(convective_flag, stratiform_flag);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int               series [$];
    int               len;
    int               v;
    int               flat_level;
    int               r;
    profile_t         profile;
    logic [37:0]      thr;
    rst = 1'b1;
    in_valid = 1'b0;
    dbz_sample = '0;
    column_end = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_BAND_BOTTOM;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register defaults: nothing is integrated
    series = {5, 127};
    send_series(series);
    drain();

    write_reg(REG_BAND_BOTTOM, 38'd2);
    write_reg(REG_BAND_TOP, 38'd6);
    write_reg(REG_ABOVE_LIMIT, 38'd10);
    write_reg(REG_MIN_SIGNAL, 38'd1);
    write_reg(REG_MEAN_THRESH, 38'd0);
    series = {127};
    send_series(series);
    // floor edge values, and a steep drop inside the band
    series = {-64, 127, -38, -37, 120, 100, 90, 50, 20, 0, -10, -64};
    send_series(series);
    drain();

    // band bottom above band top, overlapping integration ranges
    write_reg(REG_BAND_BOTTOM, 38'd6);
    write_reg(REG_BAND_TOP, 38'd2);
    write_reg(REG_ABOVE_LIMIT, 38'd9);
    write_reg(REG_MIN_SIGNAL, 38'd0);
    write_reg(REG_MEAN_THRESH, 38'h3F_FFFF_FFFF);
    series = {-37, 0, 64, 127, -38, 127, -64, 30, 30, 30};
    send_series(series);

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 4) == 0);
      flat_level = int'($urandom_range(0, 164)) - 37;
      r = $urandom_range(0, 9);
      if (r == 0) thr = '0;
      else if (r == 1) thr = 38'h3F_FFFF_FFFF;
      else thr = 38'(flags_model.linear_z(flat_level) + $urandom_range(0, 2) - 1);
      write_reg(REG_BAND_BOTTOM, 38'(pick_level()));
      write_reg(REG_BAND_TOP, 38'(pick_level()));
      write_reg(REG_ABOVE_LIMIT, 38'(pick_level()));
      r = $urandom_range(0, 9);
      write_reg(REG_MIN_SIGNAL, (r == 0) ? 38'd0 : (r == 1) ? 38'd64 :
                38'($urandom_range(0, 12)));
      write_reg(REG_MEAN_THRESH, thr);

      repeat ($urandom_range(2, 8)) begin
        r = $urandom_range(0, 9);
        if (r < 7) len = $urandom_range(1, 24);
        else if (r < 9) len = $urandom_range(25, 64);
        else len = $urandom_range(65, 80);
        profile = profile_t'($urandom_range(0, 3));
        v = int'($urandom_range(0, 191)) - 64;
        series.delete();
        for (int i = 0; i < len; i++) begin
          case (profile)
            PROFILE_NOISE: v = int'($urandom_range(0, 191)) - 64;
            PROFILE_WALK: begin
              // steps up to 6 dB give drops across the band
              v = v + int'($urandom_range(0, 24)) - 12;
              if (v < -64) v = -64;
              if (v > 127) v = 127;
            end
            PROFILE_FLOOR: v = int'($urandom_range(0, 6)) - 40;
            default: v = flat_level;
          endcase
          series.push_back(v);
        end
        send_series(series);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (flags_model.errors == 0 && flags_model.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rccc_pkg.sv
sv/radar_column_convective_classifier.sv
bench/radar_column_convective_classifier_test.sv
